[rtl/assert_macros.svh]
// Assertion macros shared by the sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SMCDF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("smcdf assertion failed");

// Antecedent in this cycle implies consequent in the next one.
`define SMCDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("smcdf assertion failed");

`endif

[rtl/smcdf_pkg.sv]
// Shared types and constants of the SPI command/data frame master.
// No dependencies; used by every module of the block.
`default_nettype none

package smcdf_pkg;

  localparam int WORD_BITS = 16;
  localparam int BC_W      = $clog2(WORD_BITS);

  localparam int DELAY_W   = 8;
  localparam int GAP_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(5);
  localparam logic [GAP_W-1:0]   GAP_RST   = GAP_W'(25);

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAP   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SELECT = 3'd2,
    PH_CMD    = 3'd3,
    PH_GAP    = 3'd4,
    PH_WDATA  = 3'd5,
    PH_RDATA  = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_ticks;
    logic [GAP_W-1:0]   gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic        sck;
    logic        mosi;
    logic        cs_first_n;
    logic        cs_second_n;
    logic        busy;
    logic        done;
    logic [15:0] read_data;
  } result_t;

endpackage

`default_nettype wire

[rtl/smcdf_cfg.sv]
// Configuration register file of the SPI frame master.
// Depends on smcdf_pkg.
`default_nettype none

module smcdf_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [smcdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [smcdf_pkg::CFG_DAT_W-1:0] cfg_data,
  output smcdf_pkg::cfg_t                      cfg_o
);

  smcdf_pkg::cfg_t cfg_r;
  smcdf_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        smcdf_pkg::CFG_DELAY: cfg_nxt.delay_ticks = cfg_data[smcdf_pkg::DELAY_W-1:0];
        smcdf_pkg::CFG_GAP:   cfg_nxt.gap_ticks   = cfg_data[smcdf_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ticks <= smcdf_pkg::DELAY_RST;
      cfg_r.gap_ticks   <= smcdf_pkg::GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/smcdf_seq.sv]
// Frame sequencer: phase, unit and bit counters, shift registers, pin levels.
// Depends on smcdf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module smcdf_seq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic        kind,
  input  wire logic        is_read,
  input  wire logic        device_sel,
  input  wire logic [15:0] address,
  input  wire logic [15:0] write_data,
  input  wire logic        miso,
  input  wire smcdf_pkg::cfg_t cfg,
  output smcdf_pkg::result_t res_o
);

  localparam int WB = smcdf_pkg::WORD_BITS;
  localparam int BW = smcdf_pkg::BC_W;
  localparam int GW = smcdf_pkg::GAP_W;

  smcdf_pkg::phase_t phase_r, phase_nxt, ph;
  logic [GW-1:0] unit_r, unit_nxt, uc;
  logic [BW-1:0] bit_r, bit_nxt, bc;
  logic [1:0]    sub_r, sub_nxt, sp;
  logic [WB-1:0] tx_r, tx_nxt, tx;
  logic [WB-1:0] hold_r, hold_nxt, hold;
  logic [WB-1:0] rx_r, rx_nxt;
  logic          rd_r, rd_nxt, rd;
  logic          dev_r, dev_nxt, dev;
  logic          start;
  logic [GW-1:0] limit;
  logic          unit_end;
  logic          bit_last;

  always_comb begin
    start = step && (phase_r == smcdf_pkg::PH_IDLE) && kind;

    ph   = phase_r;
    uc   = unit_r;
    bc   = bit_r;
    sp   = sub_r;
    tx   = tx_r;
    hold = hold_r;
    rd   = rd_r;
    dev  = dev_r;
    if (start) begin
      ph   = smcdf_pkg::PH_LEAD;
      uc   = '0;
      bc   = '0;
      sp   = '0;
      rd   = is_read;
      dev  = device_sel;
      tx   = WB'(address);
      if (is_read) tx[WB-1] = 1'b1;
      hold = WB'(write_data);
    end

    res_o.sck         = 1'b0;
    res_o.cs_first_n  = 1'b1;
    res_o.cs_second_n = 1'b1;
    res_o.busy        = 1'b0;
    res_o.done        = (ph == smcdf_pkg::PH_DONE);
    res_o.mosi        = tx[WB-1];
    res_o.read_data   = 16'(rx_r);
    if (ph != smcdf_pkg::PH_IDLE && ph != smcdf_pkg::PH_DONE) begin
      res_o.busy = 1'b1;
      if (ph != smcdf_pkg::PH_LEAD) begin
        res_o.cs_first_n  = dev;
        res_o.cs_second_n = !dev;
      end
      if (ph == smcdf_pkg::PH_CMD || ph == smcdf_pkg::PH_WDATA) begin
        res_o.sck = (sp == 2'd1);
      end else if (ph == smcdf_pkg::PH_RDATA) begin
        res_o.sck = (sp == 2'd0);
      end
    end

    limit = (ph == smcdf_pkg::PH_GAP) ? cfg.gap_ticks : GW'(cfg.delay_ticks);
    if (limit == '0) limit = GW'(1);
    unit_end = ({1'b0, uc} + (GW+1)'(1)) >= {1'b0, limit};
    bit_last = (bc == BW'(WB - 1));

    phase_nxt = ph;
    unit_nxt  = uc;
    bit_nxt   = bc;
    sub_nxt   = sp;
    tx_nxt    = tx;
    hold_nxt  = hold;
    rx_nxt    = rx_r;
    rd_nxt    = rd;
    dev_nxt   = dev;

    if (!step) begin
      phase_nxt = phase_r;
      unit_nxt  = unit_r;
      bit_nxt   = bit_r;
      sub_nxt   = sub_r;
      tx_nxt    = tx_r;
      hold_nxt  = hold_r;
      rd_nxt    = rd_r;
      dev_nxt   = dev_r;
    end else if (ph == smcdf_pkg::PH_DONE) begin
      phase_nxt = smcdf_pkg::PH_IDLE;
      unit_nxt  = '0;
    end else if (ph != smcdf_pkg::PH_IDLE) begin
      if (!unit_end) begin
        unit_nxt = uc + GW'(1);
      end else begin
        unit_nxt = '0;
        case (ph)
          smcdf_pkg::PH_LEAD: phase_nxt = smcdf_pkg::PH_SELECT;
          smcdf_pkg::PH_SELECT: begin
            phase_nxt = smcdf_pkg::PH_CMD;
            bit_nxt   = '0;
            sub_nxt   = '0;
          end
          smcdf_pkg::PH_CMD, smcdf_pkg::PH_WDATA: begin
            if (sp < 2'd2) begin
              sub_nxt = sp + 2'd1;
            end else begin
              sub_nxt = '0;
              if (bit_last) begin
                bit_nxt   = '0;
                phase_nxt = (ph == smcdf_pkg::PH_CMD) ? smcdf_pkg::PH_GAP
                                                      : smcdf_pkg::PH_DONE;
              end else begin
                bit_nxt = bc + BW'(1);
                tx_nxt  = {tx[WB-2:0], 1'b0};
              end
            end
          end
          smcdf_pkg::PH_GAP: begin
            bit_nxt = '0;
            sub_nxt = '0;
            if (rd) begin
              tx_nxt    = '0;
              phase_nxt = smcdf_pkg::PH_RDATA;
            end else begin
              tx_nxt    = hold;
              phase_nxt = smcdf_pkg::PH_WDATA;
            end
          end
          smcdf_pkg::PH_RDATA: begin
            if (sp == 2'd0) begin
              rx_nxt  = {rx_r[WB-2:0], miso};
              sub_nxt = 2'd1;
            end else begin
              sub_nxt = '0;
              if (bit_last) begin
                bit_nxt   = '0;
                phase_nxt = smcdf_pkg::PH_DONE;
              end else begin
                bit_nxt = bc + BW'(1);
              end
            end
          end
          default: phase_nxt = smcdf_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= smcdf_pkg::PH_IDLE;
      unit_r  <= '0;
      bit_r   <= '0;
      sub_r   <= '0;
      tx_r    <= '0;
      hold_r  <= '0;
      rx_r    <= '0;
      rd_r    <= 1'b0;
      dev_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      unit_r  <= unit_nxt;
      bit_r   <= bit_nxt;
      sub_r   <= sub_nxt;
      tx_r    <= tx_nxt;
      hold_r  <= hold_nxt;
      rx_r    <= rx_nxt;
      rd_r    <= rd_nxt;
      dev_r   <= dev_nxt;
    end
  end

  `SMCDF_ASSERT_NEXT(a_done_to_idle, clk, rst_n, step && phase_r == smcdf_pkg::PH_DONE, phase_r == smcdf_pkg::PH_IDLE)
  `SMCDF_ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, start, phase_r != smcdf_pkg::PH_IDLE)
  `SMCDF_ASSERT(a_one_select, clk, rst_n, res_o.cs_first_n || res_o.cs_second_n)
  `SMCDF_ASSERT(a_sub_range, clk, rst_n, sub_r != 2'd3)

endmodule

`default_nettype wire

[rtl/spi_master_cmd_data_frame.sv]
// Top level of the SPI mode-0 command/data frame master with two chip selects.
// Depends on smcdf_pkg, smcdf_cfg and smcdf_seq.
//
//   channel | direction | content
//   in_     | slave     | one clock tick of the sequencer, start request in tuser
//   out_    | master    | pin levels and status of that tick, done pulse as tlast
//   cfg_    | slave     | register index and write data
//
// Each accepted tick yields one transfer on out_ in the next cycle; one tick per cycle while in_tready is high.
// The only register between the two sides is the output register.
// in_tready drops only while a result waits and out_tready is low.
// rst_n is synchronous: config returns to delay 5 and gap 25, the sequencer to idle.
`default_nettype none

module spi_master_cmd_data_frame (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // is_read, device_sel, address[15:0],
                                      // write_data[15:0], miso, zero pad
  input  wire logic [0:0]  in_tuser,  // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // sck, mosi, cs_first_n, cs_second_n, busy_res,
                                      // read_data[15:0], zero pad
  output logic             out_tlast, // done_res
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [smcdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [smcdf_pkg::CFG_DAT_W-1:0] cfg_data
);

  smcdf_pkg::cfg_t    cfg;
  smcdf_pkg::result_t res;
  logic               step;
  logic               out_valid_r, out_valid_nxt;
  logic [23:0]        out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  smcdf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  smcdf_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .kind       (in_tuser[0]),
    .is_read    (in_tdata[0]),
    .device_sel (in_tdata[1]),
    .address    (in_tdata[17:2]),
    .write_data (in_tdata[33:18]),
    .miso       (in_tdata[34]),
    .cfg        (cfg),
    .res_o      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'b000, res.read_data, res.busy, res.cs_second_n,
                       res.cs_first_n, res.mosi, res.sck};
      out_last_nxt  = res.done;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking bench for the SPI command/data frame master: drives clock ticks
// and register writes, predicts pin levels per tick. Depends on smcdf_pkg and
// the spi_master_cmd_data_frame RTL.
`timescale 1ns / 100ps

module testbench;
  import smcdf_pkg::*;

  localparam int CYCLE_LIMIT = 600_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
  localparam int MISO_LOW    = 0;
  localparam int MISO_HIGH   = 1;
  localparam int MISO_RANDOM = 2;
  localparam int LONG_HOLD   = 300;

  class spi_pin_tracker;
    logic [DELAY_W-1:0] delay_ticks;
    logic [GAP_W-1:0]   gap_ticks;
    phase_t             ph;
    int unsigned        unit_cnt;
    int unsigned        bit_cnt;
    int unsigned        sub;
    logic [15:0]        tx_sh;
    logic [15:0]        data_hold;
    logic [15:0]        rx_sh;
    bit                 rd_flag;
    bit                 dev_flag;
    result_t            expected_pins[$];
    int                 pin_errors;

    function new();
      delay_ticks = DELAY_RST;
      gap_ticks   = GAP_RST;
      ph          = PH_IDLE;
      unit_cnt    = 0;
      bit_cnt     = 0;
      sub         = 0;
      tx_sh       = '0;
      data_hold   = '0;
      rx_sh       = '0;
      rd_flag     = 0;
      dev_flag    = 0;
      pin_errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_DELAY: delay_ticks = val[DELAY_W-1:0];
        CFG_GAP:   gap_ticks = val[GAP_W-1:0];
        default: ;
      endcase
    endfunction

    // advance one three-unit transmit bit; 1 when the word is complete
    function bit shift_tx_bit();
      if (sub < 2) begin
        sub++;
        return 0;
      end
      sub = 0;
      if (bit_cnt + 1 >= WORD_BITS) begin
        bit_cnt = 0;
        return 1;
      end
      bit_cnt++;
      tx_sh = tx_sh << 1;
      return 0;
    endfunction

    function void note_tick(bit kind, bit is_read, bit dev, logic [15:0] addr,
                            logic [15:0] wdata, bit miso);
      result_t     pin;
      int unsigned lim;
      if (ph == PH_IDLE && kind) begin
        rd_flag   = is_read;
        dev_flag  = dev;
        tx_sh     = addr;
        if (is_read) tx_sh[15] = 1'b1;
        data_hold = wdata;
        ph        = PH_LEAD;
        unit_cnt  = 0;
        bit_cnt   = 0;
        sub       = 0;
      end
      pin = '0;
      pin.cs_first_n  = 1'b1;
      pin.cs_second_n = 1'b1;
      if (ph != PH_IDLE && ph != PH_DONE) begin
        pin.busy = 1'b1;
        if (ph != PH_LEAD) begin
          if (dev_flag) pin.cs_second_n = 1'b0;
          else pin.cs_first_n = 1'b0;
        end
        if (ph == PH_CMD || ph == PH_WDATA) pin.sck = (sub == 1);
        else if (ph == PH_RDATA) pin.sck = (sub == 0);
      end
      pin.done      = (ph == PH_DONE);
      pin.mosi      = tx_sh[15];
      pin.read_data = rx_sh;
      expected_pins.push_back(pin);

      if (ph == PH_DONE) begin
        ph = PH_IDLE;
        unit_cnt = 0;
        return;
      end
      if (ph == PH_IDLE) return;
      lim = (ph == PH_GAP) ? gap_ticks : delay_ticks;
      if (lim == 0) lim = 1;
      if (unit_cnt + 1 < lim) begin
        unit_cnt++;
        return;
      end
      unit_cnt = 0;
      case (ph)
        PH_LEAD: ph = PH_SELECT;
        PH_SELECT: begin
          ph = PH_CMD;
          bit_cnt = 0;
          sub = 0;
        end
        PH_CMD: if (shift_tx_bit()) ph = PH_GAP;
        PH_GAP: begin
          bit_cnt = 0;
          sub = 0;
          if (rd_flag) begin
            tx_sh = '0;
            ph = PH_RDATA;
          end else begin
            tx_sh = data_hold;
            ph = PH_WDATA;
          end
        end
        PH_WDATA: if (shift_tx_bit()) ph = PH_DONE;
        PH_RDATA: begin
          if (sub == 0) begin
            rx_sh = {rx_sh[14:0], miso};
            sub = 1;
          end else begin
            sub = 0;
            if (bit_cnt + 1 >= WORD_BITS) begin
              bit_cnt = 0;
              ph = PH_DONE;
            end else begin
              bit_cnt++;
            end
          end
        end
        default: ph = PH_IDLE;
      endcase
    endfunction

    function void check_pins(logic [23:0] data, logic last);
      result_t got;
      result_t want;
      got.sck         = data[0];
      got.mosi        = data[1];
      got.cs_first_n  = data[2];
      got.cs_second_n = data[3];
      got.busy        = data[4];
      got.read_data   = data[20:5];
      got.done        = last;
      if (expected_pins.size() == 0) begin
        pin_errors++;
        if (pin_errors <= 10)
          $display("ERROR: transfer on out_ with nothing expected: sck=%b mosi=%b cs=%b%b",
                   got.sck, got.mosi, got.cs_first_n, got.cs_second_n);
        return;
      end
      want = expected_pins.pop_front();
      if (got !== want) begin
        pin_errors++;
        if (pin_errors <= 10) begin
          $display("ERROR: expected sck=%b mosi=%b cs1_n=%b cs2_n=%b busy=%b done=%b rd=%h",
                   want.sck, want.mosi, want.cs_first_n, want.cs_second_n, want.busy,
                   want.done, want.read_data);
          $display("       actual   sck=%b mosi=%b cs1_n=%b cs2_n=%b busy=%b done=%b rd=%h",
                   got.sck, got.mosi, got.cs_first_n, got.cs_second_n, got.busy,
                   got.done, got.read_data);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [39:0]          in_tdata;   // is_read, device_sel, address, write_data, miso, pad
  logic [0:0]           in_tuser;   // kind
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;  // sck, mosi, cs_first_n, cs_second_n, busy_res,
                                    // read_data, pad
  logic                 out_tlast;  // done_res
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  spi_pin_tracker pins = new();
  bit             offering;
  bit             idle_on;
  bit             hold_request;
  int             hold_left;
  int unsigned    cycle_count;

  spi_master_cmd_data_frame dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready level
  initial begin
    out_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) pins.check_pins(out_tdata, out_tlast);
      if (hold_request) begin
        hold_request = 0;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 11);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic bit pick_miso(int mode);
    if (mode == MISO_RANDOM) return bit'($urandom_range(0, 1));
    return mode[0];
  endfunction

  task automatic push_tick(bit kind, bit is_read, bit dev, logic [15:0] addr,
                           logic [15:0] wdata, bit miso);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      if (offering) begin
        in_tvalid <= 1'b0;
        offering = 0;
      end
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tdata <= {5'b0, miso, wdata, addr, dev, is_read};
    in_tuser <= kind;
    if (!offering) begin
      in_tvalid <= 1'b1;
      offering = 1;
    end
    do @(posedge clk); while (!in_tready);
    pins.note_tick(kind, is_read, dev, addr, wdata, miso);
  endtask

  task automatic run_ticks(int count, int start_odds);
    repeat (count)
      push_tick($urandom_range(0, start_odds) == 0, bit'($urandom_range(0, 1)),
                bit'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                bit'($urandom_range(0, 1)));
  endtask

  // finish any frame in flight, then run one frame with the given fields
  task automatic run_frame(bit is_read, bit dev, logic [15:0] addr, logic [15:0] wdata,
                           int miso_mode);
    while (pins.ph != PH_IDLE)
      push_tick(1'b0, 1'b0, 1'b0, 16'($urandom), 16'($urandom), pick_miso(miso_mode));
    push_tick(1'b1, is_read, dev, addr, wdata, pick_miso(miso_mode));
    while (pins.ph != PH_IDLE)
      push_tick($urandom_range(0, 3) == 0, bit'($urandom_range(0, 1)),
                bit'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                pick_miso(miso_mode));
  endtask

  task automatic drain_results();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 0;
    end
    while (pins.expected_pins.size() != 0) @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_IDX_W-1:0] idx_a, logic [CFG_DAT_W-1:0] val_a,
                          logic [CFG_IDX_W-1:0] idx_b, logic [CFG_DAT_W-1:0] val_b);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx_a;
    cfg_data  <= val_a;
    do @(posedge clk); while (!cfg_ready);
    pins.write_reg(idx_a, val_a);
    cfg_index <= idx_b;
    cfg_data  <= val_b;
    do @(posedge clk); while (!cfg_ready);
    pins.write_reg(idx_b, val_b);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    offering     = 0;
    idle_on      = 1;
    hold_request = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    run_ticks(150, 15);

    set_regs(CFG_DELAY, 12'd1, CFG_GAP, 12'd1);
    push_tick(1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
    run_frame(1'b0, 1'b0, 16'h0000, 16'hFFFF, MISO_HIGH);
    run_frame(1'b0, 1'b1, 16'hFFFF, 16'h0000, MISO_LOW);
    run_frame(1'b1, 1'b0, 16'h0000, 16'h1234, MISO_HIGH);
    run_frame(1'b1, 1'b1, 16'h7FFF, 16'hFFFF, MISO_LOW);
    run_frame(1'b1, 1'b0, 16'h8000, 16'h0000, MISO_RANDOM);
    run_ticks(80, 15);

    // zero lengths behave as one tick
    set_regs(CFG_DELAY, 12'd0, CFG_GAP, 12'd0);
    run_ticks(100, 7);

    // upper data bits drop on the delay register; gap wider than a byte
    set_regs(CFG_DELAY, 12'hF01, CFG_GAP, 12'd257);
    run_frame(bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)), 16'($urandom),
              16'($urandom), MISO_RANDOM);

    // longest delay, then shrink it in the middle of a unit
    set_regs(CFG_DELAY, 12'd255, CFG_GAP, 12'd2);
    run_ticks(270, 3);
    set_regs(CFG_DELAY, 12'd2, CFG_DELAY, 12'd2);
    run_ticks(200, 7);

    set_regs(CFG_SPARE_A, 12'hFFF, CFG_SPARE_B, 12'h000);
    run_ticks(50, 7);

    // stall the result side long enough to back up the input
    set_regs(CFG_DELAY, 12'd1, CFG_GAP, 12'd9);
    hold_request = 1;
    run_ticks(120, 7);
    drain_results();
    run_ticks(50, 7);

    idle_on = 0;
    set_regs(CFG_DELAY, 12'd1, CFG_GAP, 12'd3);
    run_ticks(120, 15);

    drain_results();
    repeat (20) @(posedge clk);
    if (pins.pin_errors == 0 && pins.expected_pins.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
